// ===== rtl/c8ie_pkg.sv =====
`default_nettype none
package c8ie_pkg;

	localparam int StackDepthDefault = 16;

	localparam logic [1:0] KIND_DONE  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	localparam logic [2:0] ERR_OK        = 3'd0;
	localparam logic [2:0] ERR_UNKNOWN   = 3'd1;
	localparam logic [2:0] ERR_UNDERFLOW = 3'd2;
	localparam logic [2:0] ERR_OVERFLOW  = 3'd3;
	localparam logic [2:0] ERR_BAD_KEY   = 3'd4;
	localparam logic [2:0] ERR_BAD_DIGIT = 3'd5;
	localparam logic [2:0] ERR_UNSUP     = 3'd6;

	localparam logic [1:0] CFG_FONT_BASE   = 2'd0;
	localparam logic [1:0] CFG_GLYPH_BYTES = 2'd1;
	localparam logic [1:0] CFG_START_ADDR  = 2'd2;

	typedef struct packed {
		logic [15:0] opcode;
		logic [7:0]  random_byte;
		logic [15:0] keys_down;
		logic [3:0]  key_wait_value;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  error_code;
		logic [15:0] write_address;
		logic [7:0]  write_data;
		logic [15:0] program_counter_out;
		logic [15:0] index_out;
		logic        sound_on;
		logic        last_result;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture input item, read stack
		logic exec;      // execute the captured instruction
		logic wr_store;  // emit one store write (Fx55 step or BCD step)
		logic step_done; // emit final result
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_store;   // Fx55 or Fx33 without error
		logic store_last; // current store step is the last one
	} dp_stat_t;

	// binary to BCD digits for 8-bit values; divide by ten via multiply by 205, shift 11
	function automatic logic [3:0] bcd_ones(input logic [7:0] v);
		logic [7:0] q;
		q = 8'((16'(v) * 16'd205) >> 11);
		return 4'(v - 8'(q * 8'd10));
	endfunction

	function automatic logic [3:0] bcd_tens(input logic [7:0] v);
		logic [7:0] q;
		q = 8'((16'(v) * 16'd205) >> 11);
		return bcd_ones(q);
	endfunction

	function automatic logic [3:0] bcd_hund(input logic [7:0] v);
		return (v >= 8'd200) ? 4'd2 : ((v >= 8'd100) ? 4'd1 : 4'd0);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/chip8_instruction_executor_top.sv =====
// Flow: an instruction is captured from the input transfer and executed,
// then its final result is issued; BCD first emits three write results and
// register store emits x+1, one write result per cycle while the output is
// free, set by the store sequencer in the controller. The block takes a new
// instruction only once the previous final result is issued.
// Reset (arst_n low, asynchronous): registers V0..VF, index, stack count,
// timers cleared, program counter and configuration to their defaults.
`default_nettype none
module chip8_instruction_executor_top #(
	parameter int StackDepth = c8ie_pkg::StackDepthDefault
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire c8ie_pkg::in_item_t   in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output c8ie_pkg::out_item_t       out_data,
	input  wire logic                 cfg_we,
	input  wire logic [1:0]           cfg_index,
	input  wire logic [11:0]          cfg_data
);
	import c8ie_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	c8ie_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	c8ie_dp #(.StackDepth(StackDepth)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_item  (out_data)
	);
endmodule
`default_nettype wire

// ===== rtl/c8ie_ram.sv =====
`default_nettype none
module c8ie_ram #(
	parameter int Width = 16,
	parameter int Depth = 16
) (
	input  wire logic                                               clk,
	input  wire logic                                               we,
	input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]       waddr,
	input  wire logic [Width-1:0]                                   wdata,
	input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]       raddr,
	output logic      [Width-1:0]                                   rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/c8ie_ctrl.sv =====
`default_nettype none
module c8ie_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output c8ie_pkg::dp_cmd_t        cmd,
	input  wire c8ie_pkg::dp_stat_t  stat
);
	import c8ie_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_EXEC  = 5'b00010,
		ST_STORE = 5'b00100,
		ST_FINAL = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	wire out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = stat.is_store ? ST_STORE : ST_FINAL;
			end
			ST_STORE: begin
				if (out_free) begin
					cmd.wr_store = 1'b1;
					if (stat.store_last) begin
						state_d = ST_FINAL;
					end
				end
			end
			ST_FINAL: begin
				if (out_free) begin
					cmd.step_done = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.wr_store || cmd.step_done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_EXEC)
		else $error("load did not enter exec");
	a_no_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !(cmd.wr_store || cmd.step_done))
		else $error("result overwritten while held");
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_store || cmd.step_done) |=> out_valid_q)
		else $error("emitted result not valid");
endmodule
`default_nettype wire

// ===== rtl/c8ie_dp.sv =====
`default_nettype none
module c8ie_dp #(
	parameter int StackDepth = c8ie_pkg::StackDepthDefault
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire c8ie_pkg::in_item_t   in_item,
	input  wire logic                 cfg_we,
	input  wire logic [1:0]           cfg_index,
	input  wire logic [11:0]          cfg_data,
	input  wire c8ie_pkg::dp_cmd_t    cmd,
	output c8ie_pkg::dp_stat_t        stat,
	output c8ie_pkg::out_item_t       out_item
);
	import c8ie_pkg::*;

	localparam int SpW = $clog2(StackDepth + 1);
	localparam int AW  = (StackDepth > 1) ? $clog2(StackDepth) : 1;

	logic [11:0] font_base_q, start_addr_q;
	logic [3:0]  glyph_bytes_q;
	logic [7:0]  vreg_q [16];
	logic [15:0] pc_q, index_q;
	logic [SpW-1:0] sp_q;
	logic [7:0]  delay_q, sound_q;
	logic        sound_flag_q;
	in_item_t    item_q;
	logic [3:0]  step_q;   // store step counter
	logic        bcd_q;
	logic [2:0]  err_q;
	logic [1:0]  kind_q;
	out_item_t   out_q;

	logic [15:0] stk_rdata;
	logic [AW-1:0] stk_raddr, stk_waddr;
	logic          stk_we;

	wire [15:0] op  = item_q.opcode;
	wire [3:0]  cls = op[15:12];
	wire [3:0]  x   = op[11:8];
	wire [3:0]  y   = op[7:4];
	wire [3:0]  n   = op[3:0];
	wire [7:0]  kk  = op[7:0];
	wire [11:0] nnn = op[11:0];
	wire [7:0]  vx  = vreg_q[x];
	wire [7:0]  vy  = vreg_q[y];
	wire [15:0] pc2 = pc_q + 16'd2;
	wire [15:0] pc4 = pc_q + 16'd4;

	// stack read address from the incoming opcode's point of view: sp-1
	assign stk_raddr = AW'(sp_q - SpW'(1));
	assign stk_waddr = AW'(sp_q);

	// execute decode
	logic [2:0]  e_err;
	logic [1:0]  e_kind;
	logic [15:0] e_pc, e_index;
	logic        e_wx, e_wf, e_push, e_pop, e_delay, e_sound, e_store, e_bcd;
	logic [7:0]  e_vx, e_vf;
	logic [8:0]  sum9;
	logic [15:0] font_addr;

	always_comb begin
		e_err   = ERR_OK;
		e_kind  = KIND_DONE;
		e_pc    = pc2;
		e_index = index_q;
		e_wx    = 1'b0;
		e_wf    = 1'b0;
		e_vx    = 8'd0;
		e_vf    = 8'd0;
		e_push  = 1'b0;
		e_pop   = 1'b0;
		e_delay = 1'b0;
		e_sound = 1'b0;
		e_store = 1'b0;
		e_bcd   = 1'b0;
		sum9    = 9'(vx) + 9'(vy);
		font_addr = 16'(font_base_q) + 16'(8'(glyph_bytes_q * vx[3:0]));
		case (cls)
			4'h0: begin
				if (op == 16'h00E0) begin
					e_kind = KIND_CLEAR;
				end else if (op == 16'h00EE) begin
					if (sp_q == '0) begin
						e_err = ERR_UNDERFLOW;
					end else begin
						e_pop = 1'b1;
						e_pc  = stk_rdata;
					end
				end else begin
					e_err = ERR_UNKNOWN;
				end
			end
			4'h1: e_pc = 16'(nnn);
			4'h2: begin
				if (32'(sp_q) >= StackDepth) begin
					e_err = ERR_OVERFLOW;
				end else begin
					e_push = 1'b1;
					e_pc   = 16'(nnn);
				end
			end
			4'h3: if (vx == kk) e_pc = pc4;
			4'h4: if (vx != kk) e_pc = pc4;
			4'h5: if (vx == vy) e_pc = pc4;
			4'h6: begin e_wx = 1'b1; e_vx = kk; end
			4'h7: begin e_wx = 1'b1; e_vx = vx + kk; end
			4'h8: begin
				case (n)
					4'h0: begin e_wx = 1'b1; e_vx = vy; end
					4'h1: begin e_wx = 1'b1; e_vx = vx | vy; end
					4'h2: begin e_wx = 1'b1; e_vx = vx & vy; end
					4'h3: begin e_wx = 1'b1; e_vx = vx ^ vy; end
					4'h4: begin
						e_wx = 1'b1; e_vx = sum9[7:0];
						e_wf = 1'b1; e_vf = {7'd0, sum9[8]};
					end
					4'h5: begin
						e_wx = 1'b1; e_vx = vx - vy;
						e_wf = 1'b1; e_vf = {7'd0, vx > vy};
					end
					4'h6: begin
						e_wx = 1'b1; e_vx = {1'b0, vx[7:1]};
						e_wf = 1'b1; e_vf = {7'd0, vx[0]};
					end
					4'h7: begin
						e_wx = 1'b1; e_vx = vy - vx;
						e_wf = 1'b1; e_vf = {7'd0, vy > vx};
					end
					4'hE: begin
						e_wx = 1'b1; e_vx = {vx[6:0], 1'b0};
						e_wf = 1'b1; e_vf = {7'd0, vx[7]};
					end
					default: e_err = ERR_UNKNOWN;
				endcase
			end
			4'h9: if (vx != vy) e_pc = pc4;
			4'hA: e_index = 16'(nnn);
			4'hB: e_pc = 16'(nnn) + 16'(vreg_q[0]);
			4'hC: begin e_wx = 1'b1; e_vx = item_q.random_byte & kk; end
			4'hD: e_err = ERR_UNSUP;
			4'hE: begin
				if (kk != 8'h9E && kk != 8'hA1) begin
					e_err = ERR_UNKNOWN;
				end else if (vx > 8'h0F) begin
					e_err = ERR_BAD_KEY;
				end else if (item_q.keys_down[vx[3:0]] == (kk == 8'h9E)) begin
					e_pc = pc4;
				end
			end
			default: begin
				case (kk)
					8'h07: begin e_wx = 1'b1; e_vx = delay_q; end
					8'h0A: begin e_wx = 1'b1; e_vx = {4'd0, item_q.key_wait_value}; end
					8'h15: e_delay = 1'b1;
					8'h18: e_sound = 1'b1;
					8'h1E: e_index = index_q + 16'(vx);
					8'h29: begin
						if (vx > 8'h0F) e_err = ERR_BAD_DIGIT;
						else e_index = font_addr;
					end
					8'h33: begin e_store = 1'b1; e_bcd = 1'b1; end
					8'h55: e_store = 1'b1;
					8'h65: e_err = ERR_UNSUP;
					default: e_err = ERR_UNKNOWN;
				endcase
			end
		endcase
		if (e_err != ERR_OK) begin
			e_kind = KIND_DONE;
			e_pc = pc2;
			e_index = index_q;
			e_wx = 1'b0; e_wf = 1'b0; e_push = 1'b0; e_pop = 1'b0;
			e_delay = 1'b0; e_sound = 1'b0; e_store = 1'b0; e_bcd = 1'b0;
		end
	end

	assign stk_we = cmd.exec && e_push;

	c8ie_ram #(.Width(16), .Depth(StackDepth)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (pc2),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	assign stat.is_store   = e_store;
	assign stat.store_last = bcd_q ? (step_q == 4'd2) : (step_q == x);

	// store step data
	logic [15:0] st_addr;
	logic [7:0]  st_data;
	always_comb begin
		if (bcd_q) begin
			case (step_q)
				4'd0:    begin st_addr = index_q + 16'd2; st_data = {4'd0, bcd_ones(vx)}; end
				4'd1:    begin st_addr = index_q + 16'd1; st_data = {4'd0, bcd_tens(vx)}; end
				default: begin st_addr = index_q;         st_data = {4'd0, bcd_hund(vx)}; end
			endcase
		end else begin
			st_addr = index_q + 16'(step_q);
			st_data = vreg_q[step_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			font_base_q   <= '0;
			glyph_bytes_q <= 4'd5;
			start_addr_q  <= 12'd512;
			pc_q          <= 16'd512;
			index_q       <= '0;
			sp_q          <= '0;
			delay_q       <= '0;
			sound_q       <= '0;
			sound_flag_q  <= 1'b0;
			step_q        <= '0;
			bcd_q         <= 1'b0;
			err_q         <= ERR_OK;
			kind_q        <= KIND_DONE;
			for (int i = 0; i < 16; i++) vreg_q[i] <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_FONT_BASE:   font_base_q <= cfg_data;
					CFG_GLYPH_BYTES: glyph_bytes_q <= cfg_data[3:0];
					CFG_START_ADDR: begin
						start_addr_q <= cfg_data;
						pc_q <= 16'(cfg_data);
					end
					default: ;
				endcase
			end
			if (cmd.exec) begin
				pc_q    <= e_pc;
				index_q <= e_index;
				err_q   <= e_err;
				kind_q  <= e_kind;
				bcd_q   <= e_bcd;
				step_q  <= '0;
				// flag wins when x is VF
				if (e_wx && !(e_wf && x == 4'hF)) vreg_q[x] <= e_vx;
				if (e_wf) vreg_q[15] <= e_vf;
				if (e_push) sp_q <= sp_q + SpW'(1);
				if (e_pop) sp_q <= sp_q - SpW'(1);
				if (e_delay) delay_q <= vx;
				if (e_sound) begin
					sound_q      <= vx;
					sound_flag_q <= (vx != 8'd0);
				end
			end
			if (cmd.wr_store) begin
				step_q <= step_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_item;
		end
		if (cmd.wr_store) begin
			out_q.kind                <= KIND_WRITE;
			out_q.error_code          <= ERR_OK;
			out_q.write_address       <= st_addr;
			out_q.write_data          <= st_data;
			out_q.program_counter_out <= pc_q;
			out_q.index_out           <= index_q;
			out_q.sound_on            <= sound_flag_q;
			out_q.last_result         <= 1'b0;
		end else if (cmd.step_done) begin
			out_q.kind                <= kind_q;
			out_q.error_code          <= err_q;
			out_q.write_address       <= '0;
			out_q.write_data          <= '0;
			out_q.program_counter_out <= pc_q;
			out_q.index_out           <= index_q;
			out_q.sound_on            <= sound_flag_q;
			out_q.last_result         <= 1'b1;
		end
	end

	assign out_item = out_q;

	// sound_q is kept as architectural state; only its nonzero flag leaves the block
	a_sound: assert property (@(posedge clk) disable iff (!arst_n)
		sound_flag_q == (sound_q != 8'd0))
		else $error("sound flag out of step");
	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(sp_q) <= StackDepth)
		else $error("stack count out of range");
	a_store_sp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_store |=> $stable(sp_q))
		else $error("stack moved during store");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && cfg_index == CFG_START_ADDR) |=> pc_q == 16'(start_addr_q))
		else $error("start address not loaded");
endmodule
`default_nettype wire
